/* rtl/core/hbm_pkg.sv */
// Shared types, constants and codes of the node heartbeat safety monitor.
`timescale 1ns / 1ps

package hbm_pkg;

    // Number of remote node slots (nodes 1..NODES).
    localparam int NODES = 9;

    // Field widths.
    localparam int ID_W     = 4;
    localparam int CMD_W    = 8;
    localparam int LEN_W    = 4;
    localparam int SENS_W   = 32;
    localparam int CNT_W    = 16;
    localparam int BITSEL_W = 5;
    localparam int MASK_W   = 10;

    // Slot index width.
    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ALIVE_RELOAD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFE_BIT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENT_BIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ID_REPLY_CODE = 2'd3;

    // Configuration reset values.
    localparam logic [CNT_W-1:0]    ALIVE_RELOAD_RST  = 16'd2000;
    localparam logic [BITSEL_W-1:0] SAFE_BIT_RST      = 5'd11;
    localparam logic [BITSEL_W-1:0] PRESENT_BIT_RST   = 5'd12;
    localparam logic [CMD_W-1:0]    ID_REPLY_CODE_RST = 8'd9;

    // Command queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Operation codes produced by the front classifier.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_STORE   = 2'd1;
    localparam logic [1:0] OP_NOSTORE = 2'd2;
    localparam logic [1:0] OP_IGNORE  = 2'd3;

    // One classified transaction as it travels through the queue.
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  slot;
        logic [LEN_W-1:0]  length;
        logic [SENS_W-1:0] sensors;
    } hbm_op_t;

    // Configuration that the back end uses.
    typedef struct packed {
        logic [CNT_W-1:0]    alive_reload;
        logic [BITSEL_W-1:0] safe_bit;
        logic [BITSEL_W-1:0] present_bit;
    } hbm_cfg_t;

endpackage

/* rtl/core/hbm_front.sv */
// Front end: configuration registers and classification of incoming transactions.
`timescale 1ns / 1ps

module hbm_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          kind,
    input  logic [hbm_pkg::ID_W-1:0]      node_id,
    input  logic [hbm_pkg::CMD_W-1:0]     command,
    input  logic [hbm_pkg::LEN_W-1:0]     frame_length,
    input  logic [hbm_pkg::SENS_W-1:0]    sensors,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          q_full,
    output logic                          push,
    output hbm_pkg::hbm_op_t              push_op,
    output hbm_pkg::hbm_cfg_t             cfg
);
    import hbm_pkg::*;

    logic [CNT_W-1:0]    alive_reload_reg;
    logic [BITSEL_W-1:0] safe_bit_reg;
    logic [BITSEL_W-1:0] present_bit_reg;
    logic [CMD_W-1:0]    id_reply_code_reg;
    logic                node_in_range;

    // The configuration channel never stalls.
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            alive_reload_reg  <= ALIVE_RELOAD_RST;
            safe_bit_reg      <= SAFE_BIT_RST;
            present_bit_reg   <= PRESENT_BIT_RST;
            id_reply_code_reg <= ID_REPLY_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALIVE_RELOAD:  alive_reload_reg  <= cfg_data[CNT_W-1:0];
                REG_SAFE_BIT:      safe_bit_reg      <= cfg_data[BITSEL_W-1:0];
                REG_PRESENT_BIT:   present_bit_reg   <= cfg_data[BITSEL_W-1:0];
                REG_ID_REPLY_CODE: id_reply_code_reg <= cfg_data[CMD_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.alive_reload = alive_reload_reg;
    assign cfg.safe_bit     = safe_bit_reg;
    assign cfg.present_bit  = present_bit_reg;

    // Accept whenever the queue has room.
    assign busy = q_full;
    assign push = start && !busy;

    // Classify the transaction for the back end.
    assign node_in_range = (node_id != '0) && (node_id <= ID_W'(NODES));

    always_comb
    begin
        push_op.slot    = IDX_W'(node_id - ID_W'(1));
        push_op.length  = frame_length;
        push_op.sensors = sensors;
        if (!kind)
        begin
            push_op.op = OP_TICK;
        end
        else if (command == id_reply_code_reg)
        begin
            push_op.op = OP_IGNORE;
        end
        else if (node_in_range)
        begin
            push_op.op = OP_STORE;
        end
        else
        begin
            push_op.op = OP_NOSTORE;
        end
    end

endmodule

/* rtl/core/hbm_queue.sv */
// Short queue of classified transactions between the front and back ends.
`timescale 1ns / 1ps

module hbm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  hbm_pkg::hbm_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output hbm_pkg::hbm_op_t head_op
);
    import hbm_pkg::*;

    hbm_op_t            entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign full       = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge clk) begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/core/hbm_back.sv */
// Back end: slot storage and the sequencer that walks the slots for each transaction.
`timescale 1ns / 1ps

module hbm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hbm_pkg::hbm_cfg_t          cfg,
    input  logic                       head_valid,
    input  hbm_pkg::hbm_op_t           head_op,
    output logic                       pop,
    output logic                       done,
    output logic                       safe,
    output logic                       safe_known,
    output logic [hbm_pkg::MASK_W-1:0] present_mask,
    output logic                       present_known,
    output logic [hbm_pkg::MASK_W-1:0] alive_mask
);
    import hbm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                state_reg;
    logic                state_next;
    logic [1:0]          op_reg;
    logic [1:0]          op_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                safe_acc_reg;
    logic                safe_acc_next;
    logic [MASK_W-1:0]   pres_acc_reg;
    logic [MASK_W-1:0]   pres_acc_next;
    logic [MASK_W-1:0]   alive_acc_reg;
    logic [MASK_W-1:0]   alive_acc_next;

    logic [CNT_W-1:0]    cnt_reg  [NODES];
    logic [CNT_W-1:0]    cnt_next [NODES];
    logic [LEN_W-1:0]    len_reg  [NODES];
    logic [LEN_W-1:0]    len_next [NODES];
    logic [SENS_W-1:0]   sens_reg [NODES];
    logic [SENS_W-1:0]   sens_next[NODES];

    logic                safe_reg;
    logic                safe_next;
    logic                safe_seen_reg;
    logic                safe_seen_next;
    logic [MASK_W-1:0]   present_reg;
    logic [MASK_W-1:0]   present_next;
    logic                present_seen_reg;
    logic                present_seen_next;
    logic [MASK_W-1:0]   alive_reg;
    logic [MASK_W-1:0]   alive_next;
    logic                done_reg;
    logic                done_next;

    logic [CNT_W-1:0]    cur_cnt;
    logic [LEN_W-1:0]    cur_len;
    logic [SENS_W-1:0]   cur_sens;
    logic [MASK_W-1:0]   node_hit;
    logic                last_slot;
    logic                is_tick;

    // Current slot of the walk.
    assign cur_cnt   = cnt_reg[idx_reg];
    assign cur_len   = len_reg[idx_reg];
    assign cur_sens  = sens_reg[idx_reg];
    assign last_slot = (idx_reg == IDX_W'(NODES - 1));
    assign is_tick   = (op_reg == OP_TICK);

    // Mask bit of the current slot's node number; nodes beyond the mask drop out.
    always_comb
    begin
        for (int j = 0; j < MASK_W; j++)
        begin
            node_hit[j] = (ID_W'(j) == (ID_W'(idx_reg) + ID_W'(1)));
        end
    end

    assign pop = (state_reg == ST_IDLE) && head_valid;

    // Sequencer and slot updates.
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        idx_next          = idx_reg;
        safe_acc_next     = safe_acc_reg;
        pres_acc_next     = pres_acc_reg;
        alive_acc_next    = alive_acc_reg;
        safe_next         = safe_reg;
        safe_seen_next    = safe_seen_reg;
        present_next      = present_reg;
        present_seen_next = present_seen_reg;
        alive_next        = alive_reg;
        done_next         = 1'b0;
        for (int k = 0; k < NODES; k++)
        begin
            cnt_next[k]  = cnt_reg[k];
            len_next[k]  = len_reg[k];
            sens_next[k] = sens_reg[k];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    // A status frame for a valid node lands in its slot first.
                    if (head_op.op == OP_STORE)
                    begin
                        cnt_next[head_op.slot]  = cfg.alive_reload;
                        len_next[head_op.slot]  = head_op.length;
                        sens_next[head_op.slot] = head_op.sensors;
                    end
                    op_next        = head_op.op;
                    idx_next       = '0;
                    safe_acc_next  = 1'b1;
                    pres_acc_next  = '0;
                    alive_acc_next = '0;
                    state_next     = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (is_tick)
                begin
                    if (cur_cnt == '0)
                    begin
                        len_next[idx_reg] = '0;
                    end
                    else
                    begin
                        cnt_next[idx_reg] = cur_cnt - 1'b1;
                        if (cur_sens[cfg.present_bit])
                        begin
                            pres_acc_next = pres_acc_reg | node_hit;
                        end
                        if (cur_len != '0)
                        begin
                            alive_acc_next = alive_acc_reg | node_hit;
                        end
                    end
                end
                else
                begin
                    if (cur_len != '0)
                    begin
                        alive_acc_next = alive_acc_reg | node_hit;
                        if (!cur_sens[cfg.safe_bit])
                        begin
                            safe_acc_next = 1'b0;
                        end
                    end
                end

                if (last_slot)
                begin
                    // Commit the result of the whole walk.
                    alive_next = alive_acc_next;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (is_tick)
                    begin
                        present_next      = pres_acc_next;
                        present_seen_next = 1'b1;
                    end
                    else if (op_reg != OP_IGNORE)
                    begin
                        safe_next      = safe_acc_next;
                        safe_seen_next = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            safe_reg         <= 1'b0;
            safe_seen_reg    <= 1'b0;
            present_reg      <= '1;
            present_seen_reg <= 1'b0;
            alive_reg        <= '0;
            done_reg         <= 1'b0;
            for (int k = 0; k < NODES; k++)
            begin
                cnt_reg[k]  <= '0;
                len_reg[k]  <= '0;
                sens_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            safe_reg         <= safe_next;
            safe_seen_reg    <= safe_seen_next;
            present_reg      <= present_next;
            present_seen_reg <= present_seen_next;
            alive_reg        <= alive_next;
            done_reg         <= done_next;
            for (int k = 0; k < NODES; k++)
            begin
                cnt_reg[k]  <= cnt_next[k];
                len_reg[k]  <= len_next[k];
                sens_reg[k] <= sens_next[k];
            end
        end
    end

    // Walk working registers.
    always_ff @(posedge clk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        safe_acc_reg  <= safe_acc_next;
        pres_acc_reg  <= pres_acc_next;
        alive_acc_reg <= alive_acc_next;
    end

    assign done          = done_reg;
    assign safe          = safe_reg;
    assign safe_known    = safe_seen_reg;
    assign present_mask  = present_reg;
    assign present_known = present_seen_reg;
    assign alive_mask    = alive_reg;

endmodule

/* rtl/core/node_heartbeat_safety_monitor.sv */
// Top level of the node heartbeat safety monitor.
`timescale 1ns / 1ps

// A transaction is accepted when start is high and busy is low. The back end
// takes each one from the queue in its idle state, then its sequencer walks
// the node slots in turn. The result strobe is registered at the last slot,
// and the back end already takes the next transaction during that strobe cycle.
// A two-entry queue lets up to two more transactions wait; busy is high while
// it is full. Each result appears on the result ports with done high for
// exactly one cycle, and the receiver cannot stall it. Configuration writes
// take effect at once; cfg_ready is always high.
module node_heartbeat_safety_monitor (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           kind,
    input  logic [hbm_pkg::ID_W-1:0]       node_id,
    input  logic [hbm_pkg::CMD_W-1:0]      command,
    input  logic [hbm_pkg::LEN_W-1:0]      frame_length,
    input  logic [hbm_pkg::SENS_W-1:0]     sensors,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           done,
    output logic                           safe,
    output logic                           safe_known,
    output logic [hbm_pkg::MASK_W-1:0]     present_mask,
    output logic                           present_known,
    output logic [hbm_pkg::MASK_W-1:0]     alive_mask
);
    import hbm_pkg::*;

    logic     q_full;
    logic     push;
    hbm_op_t  push_op;
    hbm_cfg_t cfg;
    logic     pop;
    logic     head_valid;
    hbm_op_t  head_op;

    hbm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .node_id      (node_id),
        .command      (command),
        .frame_length (frame_length),
        .sensors      (sensors),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .q_full       (q_full),
        .push         (push),
        .push_op      (push_op),
        .cfg          (cfg)
    );

    hbm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    hbm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head_valid    (head_valid),
        .head_op       (head_op),
        .pop           (pop),
        .done          (done),
        .safe          (safe),
        .safe_known    (safe_known),
        .present_mask  (present_mask),
        .present_known (present_known),
        .alive_mask    (alive_mask)
    );

endmodule

/* rtl/core/hbm_checker.sv */
// Port-level checks of the node heartbeat safety monitor and their binding.
`timescale 1ns / 1ps

module hbm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       done,
    input logic                       safe,
    input logic                       safe_known,
    input logic [hbm_pkg::MASK_W-1:0] present_mask,
    input logic                       present_known,
    input logic [hbm_pkg::MASK_W-1:0] alive_mask
);

    // Results are a full slot walk apart, so strobes never come back to back.
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    // Once a status frame has been seen, the safe flag stays known.
    a_safe_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(safe_known) |-> safe_known)
        else $error("safe_known dropped");

    // Once a tick has been seen, the present mask stays known.
    a_present_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(present_known) |-> present_known)
        else $error("present_known dropped");

    // The safe flag can only be set by a processed status frame.
    a_safe_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        safe |-> safe_known)
        else $error("safe set before any status frame");

    // Node numbers start at one, so bit zero of the alive mask is never set, nor that of the present mask once known.
    a_mask_bit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !alive_mask[0] && (!present_known || !present_mask[0]))
        else $error("mask bit zero set");

endmodule

bind node_heartbeat_safety_monitor hbm_checker u_hbm_checker (.*);

/* tb/sv/node_heartbeat_safety_monitor_test.sv */
// Self-checking testbench for the node heartbeat safety monitor.
`timescale 1ns / 1ps

module node_heartbeat_safety_monitor_test;

    import hbm_pkg::*;

    // Event kinds carried on the kind input.
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_PHASES   = 6;
    localparam int EVENTS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 30;

    // One input transaction: a timer tick or a received status frame.
    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   node;
        logic [CMD_W-1:0]  cmd;
        logic [LEN_W-1:0]  len;
        logic [SENS_W-1:0] sens;
    } hb_event_t;

    // One result transaction as seen on the output ports.
    typedef struct packed {
        logic              safe;
        logic              safe_known;
        logic [MASK_W-1:0] present;
        logic              present_known;
        logic [MASK_W-1:0] alive;
    } hb_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  kind = 1'b0;
    logic [ID_W-1:0]       node_id = '0;
    logic [CMD_W-1:0]      command = '0;
    logic [LEN_W-1:0]      frame_length = '0;
    logic [SENS_W-1:0]     sensors = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  done;
    logic                  safe;
    logic                  safe_known;
    logic [MASK_W-1:0]     present_mask;
    logic                  present_known;
    logic [MASK_W-1:0]     alive_mask;

    node_heartbeat_safety_monitor u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .node_id      (node_id),
        .command      (command),
        .frame_length (frame_length),
        .sensors      (sensors),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .safe         (safe),
        .safe_known   (safe_known),
        .present_mask (present_mask),
        .present_known(present_known),
        .alive_mask   (alive_mask)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the block's settings.
    logic [CNT_W-1:0]    set_reload   = ALIVE_RELOAD_RST;
    logic [BITSEL_W-1:0] set_safe_bit = SAFE_BIT_RST;
    logic [BITSEL_W-1:0] set_pres_bit = PRESENT_BIT_RST;
    logic [CMD_W-1:0]    set_id_code  = ID_REPLY_CODE_RST;

    // Shadow copy of the node slots and the status flags.
    logic [CNT_W-1:0]  slot_count [1:NODES] = '{default: '0};
    logic [LEN_W-1:0]  slot_len   [1:NODES] = '{default: '0};
    logic [SENS_W-1:0] slot_sens  [1:NODES] = '{default: '0};
    logic              safe_flag      = 1'b0;
    logic              safe_seen      = 1'b0;
    logic [MASK_W-1:0] present_flags  = '1;
    logic              present_seen   = 1'b0;

    hb_event_t  pending_events [$];
    hb_status_t expected_status [$];
    hb_event_t  offered;
    bit         offered_taken = 1'b0;
    int         idle_pct = 14;
    int         mismatches = 0;
    int         cycles = 0;

    // Apply one event to the shadow slots and queue the status it should produce.
    task automatic track_heartbeat(input hb_event_t ev);
        hb_status_t        st;
        logic [MASK_W-1:0] mask;
        logic              all_safe;
        int                n;
        if (ev.kind == KIND_TICK)
        begin
            // Expired slots lose their length; live slots count down.
            mask = '0;
            for (n = 1; n <= NODES; n++)
            begin
                if (slot_count[n] == '0)
                begin
                    slot_len[n] = '0;
                end
                else
                begin
                    slot_count[n] = slot_count[n] - 1'b1;
                    if (slot_sens[n][set_pres_bit] && n < MASK_W)
                        mask[n] = 1'b1;
                end
            end
            present_flags = mask;
            present_seen  = 1'b1;
        end
        else if (ev.cmd != set_id_code)
        begin
            // Out-of-range senders store nothing but still refresh the safe flag.
            if (ev.node >= 1 && ev.node <= NODES)
            begin
                slot_len[ev.node]   = ev.len;
                slot_sens[ev.node]  = ev.sens;
                slot_count[ev.node] = set_reload;
            end
            all_safe = 1'b1;
            for (n = 1; n <= NODES; n++)
                if (slot_len[n] != '0 && !slot_sens[n][set_safe_bit])
                    all_safe = 1'b0;
            safe_flag = all_safe;
            safe_seen = 1'b1;
        end
        st.alive = '0;
        for (n = 1; n <= NODES; n++)
            if (slot_len[n] != '0 && n < MASK_W)
                st.alive[n] = 1'b1;
        st.safe          = safe_flag;
        st.safe_known    = safe_seen;
        st.present       = present_flags;
        st.present_known = present_seen;
        expected_status.push_back(st);
    endtask

    function automatic hb_event_t tick_event();
        hb_event_t ev;
        ev      = hb_event_t'({$urandom, $urandom});
        ev.kind = KIND_TICK;
        return ev;
    endfunction

    function automatic hb_event_t frame_event(input logic [ID_W-1:0] node,
                                              input logic [CMD_W-1:0] cmd,
                                              input logic [LEN_W-1:0] len,
                                              input logic [SENS_W-1:0] sens);
        hb_event_t ev;
        ev.kind = KIND_FRAME;
        ev.node = node;
        ev.cmd  = cmd;
        ev.len  = len;
        ev.sens = sens;
        return ev;
    endfunction

    // Mostly well-formed frames from live nodes, plus ticks and some odd frames.
    function automatic hb_event_t random_event();
        hb_event_t ev;
        ev = tick_event();
        if ($urandom_range(99) >= 35)
        begin
            ev.kind = KIND_FRAME;
            if ($urandom_range(99) < 88)
                ev.node = ID_W'($urandom_range(NODES, 1));
            if ($urandom_range(99) < 85)
                ev.len = LEN_W'($urandom_range(8, 1));
            if (ev.cmd == set_id_code)
                ev.cmd = ~ev.cmd;
            if ($urandom_range(99) < 6)
                ev.cmd = set_id_code;
            ev.sens[set_safe_bit] = ($urandom_range(99) < 90);
        end
        return ev;
    endfunction

    // Write one register through the configuration channel.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_ALIVE_RELOAD:  set_reload   = value;
            REG_SAFE_BIT:      set_safe_bit = value[BITSEL_W-1:0];
            REG_PRESENT_BIT:   set_pres_bit = value[BITSEL_W-1:0];
            REG_ID_REPLY_CODE: set_id_code  = value[CMD_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input int reload, input int sbit, input int pbit,
                                 input int code);
        write_reg(REG_ALIVE_RELOAD, CFG_DATA_W'(reload));
        write_reg(REG_SAFE_BIT, CFG_DATA_W'(sbit));
        write_reg(REG_PRESENT_BIT, CFG_DATA_W'(pbit));
        write_reg(REG_ID_REPLY_CODE, CFG_DATA_W'(code));
    endtask

    // Block until every queued event is taken and every status has come back.
    task automatic drain_all();
        while (pending_events.size() != 0 || start || expected_status.size() != 0)
            @(negedge clk);
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Driver: offers the next event at the falling edge, idling at random.
    always @(negedge clk)
    begin
        if (rst_n && (!start || offered_taken))
        begin
            offered_taken = 1'b0;
            if (pending_events.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                offered = pending_events.pop_front();
                kind         <= offered.kind;
                node_id      <= offered.node;
                command      <= offered.cmd;
                frame_length <= offered.len;
                sensors      <= offered.sens;
                start        <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // An event is taken when start meets a low busy.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            offered_taken = 1'b1;
            track_heartbeat(offered);
        end
    end

    // Monitor: compare each result with the oldest expected status.
    always @(posedge clk)
    begin
        hb_status_t want;
        if (rst_n && done)
        begin
            if (expected_status.size() == 0)
            begin
                $error("result transaction with no expected status pending");
                mismatches++;
            end
            else
            begin
                want = expected_status.pop_front();
                check_field("safe", 32'(want.safe), 32'(safe));
                check_field("safe_known", 32'(want.safe_known), 32'(safe_known));
                check_field("present_mask", 32'(want.present), 32'(present_mask));
                check_field("present_known", 32'(want.present_known),
                            32'(present_known));
                check_field("alive_mask", 32'(want.alive), 32'(alive_mask));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** node_heartbeat_safety_monitor: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int n;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: safe and present flags before and after the first tick,
        // out-of-range senders, an ID reply and field extremes.
        pending_events.push_back(frame_event(4'd1, 8'h01, 4'd8, 32'h0000_1800));
        pending_events.push_back(frame_event(4'd9, 8'h42, 4'd15, 32'hFFFF_FFFF));
        pending_events.push_back(frame_event(4'd0, 8'h10, 4'd3, 32'h0000_0000));
        pending_events.push_back(frame_event(4'd15, 8'h11, 4'd7, 32'h0000_0000));
        pending_events.push_back(frame_event(4'd10, 8'h12, 4'd2, 32'h0000_0000));
        pending_events.push_back(frame_event(4'd2, ID_REPLY_CODE_RST, 4'd5, 32'h0));
        pending_events.push_back(frame_event(4'd2, 8'h20, 4'd4, 32'h0000_0000));
        pending_events.push_back(frame_event(4'd2, 8'h21, 4'd0, 32'h0000_0000));
        pending_events.push_back(tick_event());
        pending_events.push_back(frame_event(4'd5, 8'hFF, 4'd1, 32'hFFFF_FFFF));
        pending_events.push_back(frame_event(4'd3, 8'h00, 4'd2, 32'h0000_1000));
        pending_events.push_back(tick_event());
        pending_events.push_back(tick_event());
        drain_all();

        // Zero reload: a refreshed slot expires on the very next tick.
        load_settings(0, 0, 31, 0);
        pending_events.push_back(frame_event(4'd4, 8'h55, 4'd1, 32'h8000_0001));
        pending_events.push_back(tick_event());
        pending_events.push_back(frame_event(4'd6, 8'h00, 4'd3, 32'h0000_0000));
        pending_events.push_back(tick_event());
        drain_all();

        // Reload of one: counted present once, then expired.
        write_reg(REG_ALIVE_RELOAD, CFG_DATA_W'(1));
        pending_events.push_back(frame_event(4'd7, 8'h33, 4'd2, 32'h8000_0001));
        pending_events.push_back(tick_event());
        pending_events.push_back(tick_event());
        drain_all();

        // Random phases, each under its own settings.
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_all();
            case (ph)
                0: load_settings(4, 0, 31, 0);
                1: load_settings(1, 31, 0, 255);
                2: load_settings(0, $urandom_range(31), $urandom_range(31),
                                 $urandom_range(255));
                3: load_settings(65535, $urandom_range(31), $urandom_range(31),
                                 $urandom_range(255));
                4: load_settings($urandom_range(12, 2), $urandom_range(31),
                                 $urandom_range(31), $urandom_range(255));
                default: load_settings($urandom_range(8, 1), $urandom_range(31),
                                       $urandom_range(31), $urandom_range(255));
            endcase
            idle_pct = (ph == 4) ? 0 : 14;
            for (n = 0; n < EVENTS_PER_PHASE / 2; n++)
                pending_events.push_back(random_event());
            // Let the block run completely dry once in mid-phase.
            if (ph == RANDOM_PHASES - 1)
                drain_all();
            for (n = 0; n < EVENTS_PER_PHASE / 2; n++)
                pending_events.push_back(random_event());
        end

        drain_all();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** node_heartbeat_safety_monitor: PASSED **");
        else
            $display("** node_heartbeat_safety_monitor: FAILED **");
        $finish;
    end

endmodule

/* files.f */
rtl/core/hbm_pkg.sv
rtl/core/hbm_front.sv
rtl/core/hbm_queue.sv
rtl/core/hbm_back.sv
rtl/core/node_heartbeat_safety_monitor.sv
rtl/core/hbm_checker.sv
tb/sv/node_heartbeat_safety_monitor_test.sv
